// File: rtl/core/token_bucket_shaper_queue_defines.svh
// assertion macros used by the shaper top module
`ifndef TOKEN_BUCKET_SHAPER_QUEUE_DEFINES_SVH
`define TOKEN_BUCKET_SHAPER_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TBSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TBSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tbsq_pkg.sv
// types and constants of the token bucket shaper
package tbsq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_W            = 16;
	localparam int NEED_W          = 10;
	localparam int CNT_W           = 16;
	localparam int LEVEL_W         = 5;

	localparam logic [NEED_W-1:0] DEPTH_RESET = NEED_W'(10);
	localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		EV_QUEUED     = 3'd0,
		EV_DROP_LARGE = 3'd1,
		EV_DROP_FULL  = 3'd2,
		EV_TOKEN_ADD  = 3'd3,
		EV_TOKEN_DROP = 3'd4
	} event_code_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [NEED_W-1:0] need;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// File: rtl/core/tbsq_queue.sv
// packet queue storage with prefetched head entry
module tbsq_queue #(
	parameter int QUEUE_DEPTH = tbsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbsq_pkg::q_ctl_t ctl,
	input  tbsq_pkg::entry_t push_entry,
	output tbsq_pkg::entry_t head_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	tbsq_pkg::entry_t mem_q [QUEUE_DEPTH];
	tbsq_pkg::entry_t rd_data_q;
	tbsq_pkg::entry_t byp_data_q;
	logic             byp_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_d;

	assign head_d = ctl.pop ? next_slot(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			if (ctl.pop) begin
				head_q <= head_d;
			end
			if (ctl.push) begin
				tail_q <= next_slot(tail_q);
			end
			// memory reads old data when the new head slot is written this cycle
			byp_q <= ctl.push && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_q] <= push_entry;
		end
		rd_data_q  <= mem_q[head_d];
		byp_data_q <= push_entry;
	end

	assign head_entry = byp_q ? byp_data_q : rd_data_q;

endmodule

// File: rtl/core/token_bucket_shaper_queue.sv
// Token bucket shaper with a packet queue.
// Input channel item_valid/item_ready carries one event word: action 0 is a
// packet arrival (packet_id, tokens_needed), action 1 is a token tick.
// Result channel result_valid/result_ready returns exactly one word per event:
// event code, release flag and id, token and queue levels, drop totals.
// cfg_wr_en/cfg_wr_data write bucket_depth; write only while no event is pending.
// Path: an accepted event goes to the input register, then to the result register;
// a stalled result holds it back in between. Throughput: one event per cycle while
// results are taken; token count, queue pointers and fill update together per event.
// The queue is a memory with a registered read of the head slot, prefetched
// from the next head pointer so back-to-back releases need no stall.
// Reset: token count, queue pointers, fill and drop totals clear, bucket_depth
// returns to 10; queue contents are not cleared and no clearing pass is needed.
// A stalled result holds its register; the input register then fills and
// item_ready drops until result_ready returns.
module token_bucket_shaper_queue #(
	parameter int QUEUE_DEPTH = tbsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [tbsq_pkg::NEED_W-1:0]  cfg_wr_data,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         action,
	input  logic [tbsq_pkg::ID_W-1:0]    packet_id,
	input  logic [tbsq_pkg::NEED_W-1:0]  tokens_needed,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [2:0]                   event_code,
	output logic                         released,
	output logic [tbsq_pkg::ID_W-1:0]    released_id,
	output logic [tbsq_pkg::NEED_W-1:0]  token_level,
	output logic [tbsq_pkg::LEVEL_W-1:0] queue_level,
	output logic [tbsq_pkg::CNT_W-1:0]   dropped_packet_total,
	output logic [tbsq_pkg::CNT_W-1:0]   dropped_token_total
);

	`include "token_bucket_shaper_queue_defines.svh"

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

	// input register
	logic                        valid_s1;
	logic                        action_s1;
	logic [tbsq_pkg::ID_W-1:0]   pid_s1;
	logic [tbsq_pkg::NEED_W-1:0] need_s1;

	// shaper state
	logic [tbsq_pkg::NEED_W-1:0] depth_q;
	logic [tbsq_pkg::NEED_W-1:0] tok_q;
	logic [FILL_W-1:0]           fill_q;
	logic [tbsq_pkg::CNT_W-1:0]  pdrop_q;
	logic [tbsq_pkg::CNT_W-1:0]  tdrop_q;

	// result register
	logic                        out_valid_q;
	tbsq_pkg::event_code_t       ev_q;
	logic                        rel_q;
	logic [tbsq_pkg::ID_W-1:0]   rel_id_q;
	logic [FILL_W-1:0]           out_fill_q;

	logic                        fire;
	tbsq_pkg::q_ctl_t            q_ctl;
	tbsq_pkg::entry_t            new_entry;
	tbsq_pkg::entry_t            head_entry;
	tbsq_pkg::entry_t            cand;
	tbsq_pkg::event_code_t       ev_d;
	logic                        try_rel;
	logic [tbsq_pkg::NEED_W-1:0] tok_mid;
	logic [tbsq_pkg::NEED_W-1:0] tok_d;
	logic [FILL_W-1:0]           fill_mid;
	logic [FILL_W-1:0]           fill_d;
	logic [tbsq_pkg::CNT_W-1:0]  pdrop_d;
	logic [tbsq_pkg::CNT_W-1:0]  tdrop_d;
	logic [FILL_W+tbsq_pkg::LEVEL_W-1:0] fill_ext;

	assign fire       = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || fire;

	assign new_entry.id   = pid_s1;
	assign new_entry.need = need_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1 <= action;
			pid_s1    <= packet_id;
			need_s1   <= tokens_needed;
		end
	end

	always_comb begin
		ev_d     = tbsq_pkg::EV_QUEUED;
		q_ctl    = '0;
		try_rel  = 1'b0;
		tok_mid  = tok_q;
		pdrop_d  = pdrop_q;
		tdrop_d  = tdrop_q;
		if (!action_s1) begin
			if (need_s1 > depth_q) begin
				ev_d    = tbsq_pkg::EV_DROP_LARGE;
				pdrop_d = tbsq_pkg::sat_inc(pdrop_q);
			end else if (fill_q >= FILL_FULL) begin
				ev_d    = tbsq_pkg::EV_DROP_FULL;
				pdrop_d = tbsq_pkg::sat_inc(pdrop_q);
			end else begin
				q_ctl.push = fire;
				try_rel    = 1'b1;
			end
		end else begin
			if (tok_q < depth_q) begin
				ev_d    = tbsq_pkg::EV_TOKEN_ADD;
				tok_mid = tok_q + tbsq_pkg::NEED_W'(1);
			end else begin
				ev_d    = tbsq_pkg::EV_TOKEN_DROP;
				tdrop_d = tbsq_pkg::sat_inc(tdrop_q);
			end
			try_rel = 1'b1;
		end
		fill_mid = fill_q + FILL_W'(q_ctl.push);
		// an arrival into an empty queue is its own head
		cand  = (fill_q == '0) ? new_entry : head_entry;
		tok_d = tok_mid;
		if (fire && try_rel && (fill_mid != '0) && (cand.need <= tok_mid)) begin
			q_ctl.pop = 1'b1;
			tok_d     = tok_mid - cand.need;
		end
		fill_d = fill_mid - FILL_W'(q_ctl.pop);
	end

	tbsq_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (q_ctl),
		.push_entry (new_entry),
		.head_entry (head_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= tbsq_pkg::DEPTH_RESET;
			tok_q       <= '0;
			fill_q      <= '0;
			pdrop_q     <= '0;
			tdrop_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				depth_q <= cfg_wr_data;
			end
			if (fire) begin
				tok_q   <= tok_d;
				fill_q  <= fill_d;
				pdrop_q <= pdrop_d;
				tdrop_q <= tdrop_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q       <= ev_d;
			rel_q      <= q_ctl.pop;
			rel_id_q   <= q_ctl.pop ? cand.id : '0;
			out_fill_q <= fill_d;
		end
	end

	assign fill_ext = {{tbsq_pkg::LEVEL_W{1'b0}}, out_fill_q};

	assign result_valid         = out_valid_q;
	assign event_code           = ev_q;
	assign released             = rel_q;
	assign released_id          = rel_id_q;
	assign token_level          = tok_q;
	assign queue_level          = fill_ext[tbsq_pkg::LEVEL_W-1:0];
	assign dropped_packet_total = pdrop_q;
	assign dropped_token_total  = tdrop_q;

	`TBSQ_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_FULL, "queue fill over depth")
	`TBSQ_ASSERT_NOW(a_no_rel_on_drop, clk, arst_n, out_valid_q && rel_q,
		(ev_q != tbsq_pkg::EV_DROP_LARGE) && (ev_q != tbsq_pkg::EV_DROP_FULL),
		"release on a dropped packet")
	`TBSQ_ASSERT_NEXT(a_hold_s1, clk, arst_n, valid_s1 && !fire,
		valid_s1 && $stable(pid_s1) && $stable(need_s1) && $stable(action_s1),
		"pending word lost from input register")

endmodule

// File: tb/tb_token_bucket_shaper_queue.sv
// self-checking testbench for token_bucket_shaper_queue with its scoreboard class
package tb_shaper_pkg;
	import tbsq_pkg::*;

	localparam logic ACT_ARRIVAL = 1'b0;
	localparam logic ACT_TICK    = 1'b1;
	localparam int   REPORT_CAP  = 100;

	typedef struct packed {
		event_code_t        code;
		logic               rel;
		logic [ID_W-1:0]    rel_id;
		logic [NEED_W-1:0]  tokens;
		logic [LEVEL_W-1:0] fill;
		logic [CNT_W-1:0]   pkt_drops;
		logic [CNT_W-1:0]   tok_drops;
	} shaper_outcome_t;

	class shaper_scoreboard;
		int                queue_cap;
		logic [NEED_W-1:0] depth;
		logic [NEED_W-1:0] tokens;
		entry_t            waiting[$];
		logic [CNT_W-1:0]  pkt_drops;
		logic [CNT_W-1:0]  tok_drops;
		shaper_outcome_t   pending_outcomes[$];
		int unsigned       errors;

		function new(int cap);
			queue_cap = cap;
			depth     = DEPTH_RESET;
			tokens    = '0;
			pkt_drops = '0;
			tok_drops = '0;
			errors    = 0;
		endfunction

		function void set_depth(logic [NEED_W-1:0] d);
			depth = d;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		// predict the word the block returns for one accepted event
		function void note_event(logic act, logic [ID_W-1:0] id, logic [NEED_W-1:0] need);
			shaper_outcome_t o;
			logic            try_release;
			try_release = 1'b0;
			o.rel       = 1'b0;
			o.rel_id    = '0;
			if (act == ACT_ARRIVAL) begin
				if (need > depth) begin
					o.code    = EV_DROP_LARGE;
					pkt_drops = (pkt_drops == CNT_MAX) ? pkt_drops : pkt_drops + 1'b1;
				end else if (waiting.size() >= queue_cap) begin
					o.code    = EV_DROP_FULL;
					pkt_drops = (pkt_drops == CNT_MAX) ? pkt_drops : pkt_drops + 1'b1;
				end else begin
					o.code = EV_QUEUED;
					waiting.push_back('{id: id, need: need});
					try_release = 1'b1;
				end
			end else begin
				if (tokens < depth) begin
					tokens = tokens + 1'b1;
					o.code = EV_TOKEN_ADD;
				end else begin
					tok_drops = (tok_drops == CNT_MAX) ? tok_drops : tok_drops + 1'b1;
					o.code    = EV_TOKEN_DROP;
				end
				try_release = 1'b1;
			end
			if (try_release && waiting.size() > 0 && waiting[0].need <= tokens) begin
				tokens   = tokens - waiting[0].need;
				o.rel    = 1'b1;
				o.rel_id = waiting[0].id;
				void'(waiting.pop_front());
			end
			o.tokens    = tokens;
			o.fill      = LEVEL_W'(waiting.size());
			o.pkt_drops = pkt_drops;
			o.tok_drops = tok_drops;
			pending_outcomes.push_back(o);
		endfunction

		// printing stops after a cap so a broken block cannot flood the log
		task report(string msg);
			if (errors < REPORT_CAP)
				$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_result(shaper_outcome_t got);
			shaper_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				report("result word with nothing outstanding");
				return;
			end
			want = pending_outcomes.pop_front();
			compare_field("event_code", 32'(got.code), 32'(want.code));
			compare_field("released", 32'(got.rel), 32'(want.rel));
			compare_field("released_id", 32'(got.rel_id), 32'(want.rel_id));
			compare_field("token_level", 32'(got.tokens), 32'(want.tokens));
			compare_field("queue_level", 32'(got.fill), 32'(want.fill));
			compare_field("dropped_packet_total", 32'(got.pkt_drops), 32'(want.pkt_drops));
			compare_field("dropped_token_total", 32'(got.tok_drops), 32'(want.tok_drops));
		endtask
	endclass
endpackage

module tb_token_bucket_shaper_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import tbsq_pkg::*;
	import tb_shaper_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                cfg_wr_en     = 1'b0;
	logic [NEED_W-1:0]   cfg_wr_data   = DEPTH_RESET;
	logic                item_valid    = 1'b0;
	logic                item_ready;
	logic                action        = ACT_ARRIVAL;
	logic [ID_W-1:0]     packet_id     = '0;
	logic [NEED_W-1:0]   tokens_needed = '0;
	logic                result_valid;
	logic                result_ready  = 1'b0;
	logic [2:0]          event_code;
	logic                released;
	logic [ID_W-1:0]     released_id;
	logic [NEED_W-1:0]   token_level;
	logic [LEVEL_W-1:0]  queue_level;
	logic [CNT_W-1:0]    dropped_packet_total;
	logic [CNT_W-1:0]    dropped_token_total;

	int send_idle_pct = 0;
	int stall_pct     = 0;

	shaper_scoreboard sb = new(QDEPTH);

	token_bucket_shaper_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_wr_data          (cfg_wr_data),
		.item_valid           (item_valid),
		.item_ready           (item_ready),
		.action               (action),
		.packet_id            (packet_id),
		.tokens_needed        (tokens_needed),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.event_code           (event_code),
		.released             (released),
		.released_id          (released_id),
		.token_level          (token_level),
		.queue_level          (queue_level),
		.dropped_packet_total (dropped_packet_total),
		.dropped_token_total  (dropped_token_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("tb_token_bucket_shaper_queue failed");
		$finish;
	end

	// result side: check the accepted word, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result('{code: event_code_t'(event_code), rel: released,
				rel_id: released_id, tokens: token_level, fill: queue_level,
				pkt_drops: dropped_packet_total, tok_drops: dropped_token_total});
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_event(input logic act, input logic [ID_W-1:0] id,
			input logic [NEED_W-1:0] need);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid    <= 1'b1;
		action        <= act;
		packet_id     <= id;
		tokens_needed <= need;
		do @(posedge clk); while (!item_ready);
		sb.note_event(act, id, need);
	endtask

	task automatic send_random(input int tick_pct);
		logic [NEED_W-1:0] lim;
		logic [NEED_W-1:0] need;
		int                r;
		lim = (sb.depth < 8) ? sb.depth : NEED_W'(8);
		r   = $urandom_range(99);
		// mostly needs the bucket can serve, a few from the full range that may be dropped as too large
		if (r < 70)
			need = NEED_W'($urandom_range(lim, 0));
		else if (r < 90)
			need = NEED_W'($urandom_range(sb.depth, 0));
		else
			need = NEED_W'($urandom_range(1023, 0));
		send_event(($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_ARRIVAL,
			ID_W'($urandom()), need);
	endtask

	// bucket depth changes only once every outstanding word has come back
	task automatic write_depth(input logic [NEED_W-1:0] d);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_depth(d);
	endtask

	task automatic random_phase(input int send_pct, input int stall, input int count);
		int tick_pct;
		send_idle_pct = send_pct;
		stall_pct     = stall;
		tick_pct      = 50;
		for (int i = 0; i < count; i++) begin
			// every 40 events pick a new tick share at random so the queue and bucket hit their limits
			if (i % 40 == 0)
				case ($urandom_range(2))
					0: tick_pct = 25;
					1: tick_pct = 50;
					default: tick_pct = 75;
				endcase
			send_random(tick_pct);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset depth: free packet, oversized packet, packet that waits for a full bucket
		send_event(ACT_ARRIVAL, 16'hFFFF, 10'd0);
		send_event(ACT_ARRIVAL, 16'h0000, 10'd1023);
		send_event(ACT_ARRIVAL, 16'h5555, 10'd10);
		repeat (10) send_event(ACT_TICK, ID_W'($urandom()), NEED_W'($urandom()));

		// zero depth: only free packets pass, every tick drops
		write_depth('0);
		send_event(ACT_ARRIVAL, 16'hAAAA, 10'd0);
		send_event(ACT_ARRIVAL, 16'h0F0F, 10'd1);
		send_event(ACT_TICK, 16'h1234, 10'd3);

		// depth lowered under the tokens already held
		write_depth(10'd1023);
		repeat (3) send_event(ACT_TICK, ID_W'($urandom()), NEED_W'($urandom()));
		write_depth(10'd1);
		send_event(ACT_TICK, ID_W'($urandom()), NEED_W'($urandom()));
		send_event(ACT_ARRIVAL, 16'h00F0, 10'd1);

		write_depth(10'd1023);
		random_phase(0, 0, 280);
		write_depth(NEED_W'($urandom_range(16, 2)));
		random_phase(59, 0, 280);
		write_depth(10'd1);
		random_phase(0, 59, 280);
		write_depth(NEED_W'($urandom_range(1023, 1)));
		random_phase(15, 15, 280);

		write_depth(DEPTH_RESET);
		random_phase(15, 15, 60);

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_token_bucket_shaper_queue passed");
		else
			$display("tb_token_bucket_shaper_queue failed");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tbsq_pkg.sv
rtl/core/tbsq_queue.sv
rtl/core/token_bucket_shaper_queue.sv
tb/tb_token_bucket_shaper_queue.sv
